FILE: src/rainbow_breathing_frame_generator_core_macros.svh
// Assertion macros shared by the rainbow frame generator RTL.
// The modules that include this header use clk and arst_n as clock and reset.
`ifndef RAINBOW_BREATHING_FRAME_GENERATOR_CORE_MACROS_SVH
`define RAINBOW_BREATHING_FRAME_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define RBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define RBF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RBF_ASSERT(lbl, prop, msg)
`define RBF_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/rbf_pkg.sv
// Package of the rainbow frame generator: types, codes, constants, sine entry function.
// Depends on nothing; rbf_div, rbf_cfg and the top level import it.
package rbf_pkg;

	localparam int MAX_LEDS     = 64;
	localparam int SINE_ENTRIES = 256;
	localparam int SINE_AW      = $clog2(SINE_ENTRIES);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Width of the shared divider; v*rem and 6*i both fit in it.
	localparam int DIV_W  = 14;
	localparam int DVS_W  = 7;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	localparam logic [6:0]  RST_LED_COUNT  = 7'd8;
	localparam logic [7:0]  RST_STATIC_BRT = 8'd48;
	localparam logic [7:0]  RST_BR_HIGH    = 8'd72;
	localparam logic [7:0]  RST_BR_LOW     = 8'd0;
	localparam logic [15:0] RST_PHASE_STEP = 16'd1252;

	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		REQ_STATIC  = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_SPEAK   = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LED_COUNT  = 3'd0,
		CFG_STATIC_BRT = 3'd1,
		CFG_BR_HIGH    = 3'd2,
		CFG_BR_LOW     = 3'd3,
		CFG_PHASE_STEP = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0]  led_count;
		logic [7:0]  static_brightness;
		logic [7:0]  breathe_high;
		logic [7:0]  breathe_low;
		logic [15:0] phase_step;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_stat_t;

	// One sine entry in Q1.15, from a Q30 Taylor series on the first quadrant.
	// Only evaluated at elaboration to build the constant table.
	function automatic logic signed [15:0] sine_entry(int unsigned k);
		longint unsigned a;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          r;
		logic            neg;
		logic signed [15:0] res;
		a   = (longint'(k % SINE_ENTRIES) * TWO_PI_Q30) / SINE_ENTRIES;
		neg = 1'b0;
		if (a >= PI_Q30) begin
			neg = 1'b1;
			a   = a - PI_Q30;
		end
		if (a > HALF_PI_Q30)
			a = PI_Q30 - a;
		x2   = (a * a) >> 30;
		term = a;
		sum  = longint'(a);
		// Seven series terms; the divisors are (2n)(2n+1) for n = 1..7, signs alternate.
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		r = (sum * 32767 + (longint'(1) << 29)) >>> 30;
		if (r > 32767)
			r = 32767;
		res = r[15:0];
		if (neg)
			res = -res;
		return res;
	endfunction

endpackage

FILE: src/rbf_ifs.sv
// Valid/ready channel interfaces of the rainbow frame generator.
// Depends on nothing; used by the top level.

interface rbf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       playback_active;

	modport source (output valid, output req_type, output playback_active, input ready);
	modport sink   (input valid, input req_type, input playback_active, output ready);
endinterface

interface rbf_pix_if;
	logic       valid;
	logic       ready;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       frame_last;

	modport source (output valid, output pixel_index, output red, output green, output blue,
		output frame_last, input ready);
	modport sink   (input valid, input pixel_index, input red, input green, input blue,
		input frame_last, output ready);
endinterface

FILE: src/rbf_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rbf_pkg and the assertion macro header.
`include "rainbow_breathing_frame_generator_core_macros.svh"

module rbf_div
	import rbf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_ctl_t  ctl,
	output div_stat_t stat
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
				rem_q  <= '0;
				quo_q  <= ctl.dividend;
				dvs_q  <= ctl.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = quo_q;
	assign stat.rem  = rem_q;

	`RBF_ASSERT(a_rem_below_divisor, (done_q && dvs_q != '0) |-> (rem_q < dvs_q), "remainder not below divisor")
	`RBF_ASSERT(a_done_pulse, done_q |=> !done_q, "done held longer than one cycle")
	`RBF_ASSERT(a_busy_count, busy_q |-> (cnt_q != '0), "busy with an empty bit count")

endmodule

FILE: src/rbf_cfg.sv
// Configuration register file of the rainbow frame generator.
// Depends on rbf_pkg.

module rbf_cfg
	import rbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count         <= RST_LED_COUNT;
			cfg_q.static_brightness <= RST_STATIC_BRT;
			cfg_q.breathe_high      <= RST_BR_HIGH;
			cfg_q.breathe_low       <= RST_BR_LOW;
			cfg_q.phase_step        <= RST_PHASE_STEP;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_LED_COUNT:  cfg_q.led_count         <= wdata[6:0];
				CFG_STATIC_BRT: cfg_q.static_brightness <= wdata[7:0];
				CFG_BR_HIGH:    cfg_q.breathe_high      <= wdata[7:0];
				CFG_BR_LOW:     cfg_q.breathe_low       <= wdata[7:0];
				CFG_PHASE_STEP: cfg_q.phase_step        <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/rainbow_breathing_frame_generator_core.sv
// Rainbow frame generator with sine breathing: sequencer, breathing datapath and output stage.
// Depends on rbf_pkg, rbf_ifs, rbf_cfg, rbf_div and the assertion macro header.
//
// Each request beat on req (req_type, playback_active) produces one frame of pixel beats
// on pix, one beat per pixel in strip order, with frame_last set on the final pixel.
// The frame length is led_count, limited to 1..64. Registers are to be written by the user through
// the plain cfg_we / cfg_index / cfg_wdata port only while no frame is in progress; the block
// itself does not enforce this. req.ready is high only while the sequencer is idle; one
// request is handled at a time. A breathing request first steps through the sine lookup,
// squaring, scaling and low-level add states; then every pixel takes two passes through
// the shared 14-bit divider (sector and remainder of 6*i/N, then v*rem/N), one quotient
// bit per cycle, and then loads the output register. The next pixel is computed while
// the current one waits in the output register; if the receiver stalls longer, the
// sequencer holds until the register frees.
// Reset clears the registers to their defaults, the breathing phase to zero and empties
// the output register; no frame is pending after reset.
`include "rainbow_breathing_frame_generator_core_macros.svh"

module rainbow_breathing_frame_generator_core
	import rbf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rbf_req_if.sink               req,
	rbf_pix_if.source             pix,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// One-hot sequencer states.
	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_SINE     = 10'b0000000010,
		ST_SQUARE   = 10'b0000000100,
		ST_SCALE    = 10'b0000001000,
		ST_LEVEL    = 10'b0000010000,
		ST_SEC_GO   = 10'b0000100000,
		ST_SEC_WAIT = 10'b0001000000,
		ST_HUE_GO   = 10'b0010000000,
		ST_HUE_WAIT = 10'b0100000000,
		ST_EMIT     = 10'b1000000000
	} state_t;

	cfg_t      cfg;
	div_ctl_t  div_ctl;
	div_stat_t div_stat;

	rbf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	rbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.stat   (div_stat)
	);

	// Constant sine table in Q1.15, built at elaboration.
	logic signed [15:0] sine_rom [SINE_ENTRIES];
	for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
		assign sine_rom[k] = sine_entry(k);
	end

	state_t      state_q;
	logic [15:0] phase_q;
	logic [7:0]  v_q;
	logic        lit_q;
	logic [14:0] half_q;
	logic [29:0] sq_q;
	logic [7:0]  scaled_q;
	logic [5:0]  pix_i_q;
	logic [2:0]  sector_q;
	logic [5:0]  rem_q;
	logic [7:0]  t_q;
	logic        frac_q;

	logic       out_valid_q;
	logic [5:0] out_index_q;
	logic [7:0] out_red_q;
	logic [7:0] out_green_q;
	logic [7:0] out_blue_q;
	logic       out_last_q;

	logic [6:0]  n_cnt;
	logic [7:0]  span;
	logic [16:0] biased;
	logic [37:0] scale_prod;
	logic [8:0]  level;
	logic [7:0]  q_val;
	logic [7:0]  red_c;
	logic [7:0]  green_c;
	logic [7:0]  blue_c;
	logic        is_last;
	logic        out_free;
	logic        emit_load;
	logic        req_acc;

	// Frame length limited to 1..MAX_LEDS.
	always_comb begin
		n_cnt = cfg.led_count;
		if (cfg.led_count == 7'd0)
			n_cnt = 7'd1;
		else if (cfg.led_count > 7'(MAX_LEDS))
			n_cnt = 7'(MAX_LEDS);
	end

	// A low level above the high level gives no breathing swing.
	assign span       = (cfg.breathe_high > cfg.breathe_low) ?
		(cfg.breathe_high - cfg.breathe_low) : 8'd0;
	// (sin + 1) / 2 in Q15: the sign-extended entry plus one, halved.
	assign biased     = {sine_rom[phase_q[15 -: SINE_AW]][15], sine_rom[phase_q[15 -: SINE_AW]]}
		+ 17'h08000;
	assign scale_prod = 38'(span) * 38'(sq_q);
	assign level      = 9'(cfg.breathe_low) + 9'(scaled_q);

	// q = floor(v*(N-rem)/N) equals v minus the ceiling of v*rem/N.
	assign q_val = v_q - t_q - 8'(frac_q);

	always_comb begin
		red_c   = 8'd0;
		green_c = 8'd0;
		blue_c  = 8'd0;
		if (lit_q) begin
			case (sector_q)
				3'd0: begin
					red_c   = v_q;
					green_c = t_q;
				end
				3'd1: begin
					red_c   = q_val;
					green_c = v_q;
				end
				3'd2: begin
					green_c = v_q;
					blue_c  = t_q;
				end
				3'd3: begin
					green_c = q_val;
					blue_c  = v_q;
				end
				3'd4: begin
					red_c   = t_q;
					blue_c  = v_q;
				end
				default: begin
					red_c   = v_q;
					blue_c  = q_val;
				end
			endcase
		end
	end

	assign is_last   = ({1'b0, pix_i_q} + 7'd1) == n_cnt;
	assign out_free  = !out_valid_q || pix.ready;
	assign emit_load = (state_q == ST_EMIT) && out_free;
	assign req_acc   = req.valid && req.ready;

	// Divider requests: first the sector split of 6*i, then the hue ramp v*rem.
	always_comb begin
		div_ctl.start    = 1'b0;
		div_ctl.dividend = 14'(pix_i_q) * 14'd6;
		div_ctl.divisor  = n_cnt;
		case (state_q)
			ST_SEC_GO: div_ctl.start = 1'b1;
			ST_HUE_GO: begin
				div_ctl.start    = 1'b1;
				div_ctl.dividend = 14'(v_q) * 14'(rem_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new pixel loads the output register; otherwise an accepted beat empties it.
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (pix.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						pix_i_q <= '0;
						lit_q   <= (req_kind_t'(req.req_type) != REQ_SPEAK) ||
							req.playback_active;
						v_q     <= cfg.static_brightness;
						case (req_kind_t'(req.req_type))
							REQ_RESTART: begin
								phase_q <= cfg.phase_step;
								state_q <= ST_SINE;
							end
							REQ_TICK: begin
								phase_q <= phase_q + cfg.phase_step;
								state_q <= ST_SINE;
							end
							REQ_SPEAK: begin
								state_q <= ST_SEC_GO;
							end
							default: state_q <= ST_SEC_GO;
						endcase
					end
				end
				ST_SINE: begin
					half_q  <= biased[15:1];
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					sq_q    <= 30'(half_q) * 30'(half_q);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					scaled_q <= scale_prod[37:30];
					state_q  <= ST_LEVEL;
				end
				ST_LEVEL: begin
					v_q     <= level[8] ? 8'hFF : level[7:0];
					state_q <= ST_SEC_GO;
				end
				ST_SEC_GO: state_q <= ST_SEC_WAIT;
				ST_SEC_WAIT: begin
					if (div_stat.done) begin
						sector_q <= div_stat.quot[2:0];
						rem_q    <= div_stat.rem[5:0];
						state_q  <= ST_HUE_GO;
					end
				end
				ST_HUE_GO: state_q <= ST_HUE_WAIT;
				ST_HUE_WAIT: begin
					if (div_stat.done) begin
						t_q     <= div_stat.quot[7:0];
						frac_q  <= div_stat.rem != '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_index_q <= pix_i_q;
						out_red_q   <= red_c;
						out_green_q <= green_c;
						out_blue_q  <= blue_c;
						out_last_q  <= is_last;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							pix_i_q <= pix_i_q + 6'd1;
							state_q <= ST_SEC_GO;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready       = state_q == ST_IDLE;
	assign pix.valid       = out_valid_q;
	assign pix.pixel_index = out_index_q;
	assign pix.red         = out_red_q;
	assign pix.green       = out_green_q;
	assign pix.blue        = out_blue_q;
	assign pix.frame_last  = out_last_q;

	`RBF_NEVER(a_div_start_busy, div_ctl.start && div_stat.busy, "divider started while busy")
	`RBF_ASSERT(a_static_phase, (req_acc && req.req_type != REQ_RESTART && req.req_type != REQ_TICK) |=> (phase_q == $past(phase_q)), "phase moved on a non-breathing frame")
	`RBF_ASSERT(a_restart_phase, (req_acc && req.req_type == REQ_RESTART) |=> (phase_q == $past(cfg.phase_step)), "restart did not reset the phase")

endmodule
